>>> src/lcts_pkg.sv
// Shared types, constants and operation codes for the load-cell tare/span scaler.
// No dependencies; every other file refers to it by scoped names.
package lcts_pkg;

	localparam int BLOCK_LEN_DEF   = 15;
	localparam int SAMPLE_BITS_DEF = 16;

	// Field widths
	localparam int SAMPLE_W = 16;
	localparam int ADDR_W   = 7;
	localparam int VALUE_W  = 16;
	localparam int WEIGHT_W = 32;
	localparam int AVG_W    = 16;
	localparam int ERR_W    = 1;

	localparam int ADDR_LSB  = SAMPLE_W;
	localparam int VALUE_LSB = SAMPLE_W + ADDR_W;

	localparam int IN_FIELDS_W  = SAMPLE_W + ADDR_W + VALUE_W;
	localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_FIELDS_W = WEIGHT_W + AVG_W + ERR_W;
	localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

	// Action kinds carried on tuser
	localparam logic ACT_SAMPLE = 1'b0;
	localparam logic ACT_WRITE  = 1'b1;

	// Holding registers
	localparam logic [ADDR_W-1:0]  REG_ZERO = 7'd42;
	localparam logic [ADDR_W-1:0]  REG_SPAN = 7'd43;
	localparam logic [VALUE_W-1:0] ZERO_CMD = 16'd1;

	// Q16.16 coefficient
	localparam int              Q_FRAC = 16;
	localparam int              COEF_W = 32;
	localparam logic [COEF_W-1:0] Q_ONE = 32'd65536;

	// Shared unit geometry
	localparam int HI_W      = 32;
	localparam int LO_W      = 16;
	localparam int DIV_STEPS = HI_W;
	localparam int MUL_STEPS = LO_W;
	localparam int STEP_W    = $clog2(DIV_STEPS);

	// Shared unit operations
	localparam logic [2:0] OP_NOP      = 3'd0;
	localparam logic [2:0] OP_DIV_LOAD = 3'd1;
	localparam logic [2:0] OP_DIV_STEP = 3'd2;
	localparam logic [2:0] OP_MUL_LOAD = 3'd3;
	localparam logic [2:0] OP_MUL_STEP = 3'd4;

	typedef struct packed {
		logic [2:0]      op;
		logic [HI_W-1:0] opa;   // dividend or multiplicand
		logic [LO_W-1:0] opb;   // divisor or multiplier
	} arith_ctl_t;

endpackage

>>> src/lcts_arith.sv
// Shared shift/add unit: restoring division and shift-add multiplication, one bit a cycle.
// Depends on lcts_pkg.
module lcts_arith (
	input  logic                                       clk,
	input  lcts_pkg::arith_ctl_t                       ctl,
	output logic [lcts_pkg::HI_W-1:0]                  quo,
	output logic [lcts_pkg::HI_W+lcts_pkg::LO_W-1:0]   prod
);

	logic [lcts_pkg::HI_W-1:0] hi_q;
	logic [lcts_pkg::LO_W-1:0] lo_q;
	logic [lcts_pkg::HI_W-1:0] opnd_q;

	logic [lcts_pkg::LO_W:0]   rem_sh;
	logic [lcts_pkg::HI_W:0]   add_a;
	logic [lcts_pkg::HI_W:0]   add_b;
	logic                      add_ci;
	logic [lcts_pkg::HI_W:0]   add_sum;
	logic                      div_ok;

	// One adder serves both operations
	always_comb begin
		rem_sh = {lo_q, hi_q[lcts_pkg::HI_W-1]};
		case (ctl.op)
			lcts_pkg::OP_DIV_STEP: begin
				add_a  = {{(lcts_pkg::HI_W-lcts_pkg::LO_W){1'b0}}, rem_sh};
				add_b  = ~{{(lcts_pkg::HI_W-lcts_pkg::LO_W+1){1'b0}}, opnd_q[lcts_pkg::LO_W-1:0]};
				add_ci = 1'b1;
			end
			default: begin
				add_a  = {1'b0, hi_q};
				add_b  = lo_q[0] ? {1'b0, opnd_q} : '0;
				add_ci = 1'b0;
			end
		endcase
		add_sum = add_a + add_b + {{lcts_pkg::HI_W{1'b0}}, add_ci};
		div_ok  = ~add_sum[lcts_pkg::HI_W];
	end

	always_ff @(posedge clk) begin
		case (ctl.op)
			lcts_pkg::OP_DIV_LOAD: begin
				hi_q   <= ctl.opa;
				lo_q   <= '0;
				opnd_q <= {{(lcts_pkg::HI_W-lcts_pkg::LO_W){1'b0}}, ctl.opb};
			end
			lcts_pkg::OP_DIV_STEP: begin
				hi_q <= {hi_q[lcts_pkg::HI_W-2:0], div_ok};
				lo_q <= div_ok ? add_sum[lcts_pkg::LO_W-1:0] : rem_sh[lcts_pkg::LO_W-1:0];
			end
			lcts_pkg::OP_MUL_LOAD: begin
				hi_q   <= '0;
				lo_q   <= ctl.opb;
				opnd_q <= ctl.opa;
			end
			lcts_pkg::OP_MUL_STEP: begin
				hi_q <= add_sum[lcts_pkg::HI_W:1];
				lo_q <= {add_sum[0], lo_q[lcts_pkg::LO_W-1:1]};
			end
			default: ;
		endcase
	end

	assign quo  = hi_q;
	assign prod = {hi_q, lo_q};

endmodule

>>> src/load_cell_tare_span_scaler_unit.sv
// Top level of the load-cell tare/span scaler: sequencer, calibration state, output register.
// Depends on lcts_pkg and lcts_arith.
//
// Each input word is either a converter sample (tuser = 0) or a holding-register write
// (tuser = 1). Samples are summed in blocks of BLOCK_LEN; at the end of each block the
// average is the truncated block sum divided by BLOCK_LEN. A write of 1 to register 42
// takes the current average as the zero; a write to register 43 sets the Q16.16 span
// coefficient to value*65536 / (average - zero), truncated toward zero, or raises
// cal_error on that result and keeps the old coefficient when the difference is zero.
// Every input word yields exactly one output word carrying the weight
// (average - zero) * coefficient / 65536, truncated toward zero and saturated to 32 bits,
// together with the latest block average. All arithmetic runs one bit per cycle through
// a single shared shift/add unit: a word that neither closes a block nor sets the span
// passes through the multiply load, 16 multiply steps and the output hand-off. A word
// that closes a block or sets the span first runs 32 division steps and the write-back
// (the divider load shares the accept cycle). s_tready is high only while the sequencer
// is idle; a finished result waits in the output register, so the next word can be
// taken before the previous one is drained.
module load_cell_tare_span_scaler_unit #(
	parameter int BLOCK_LEN   = lcts_pkg::BLOCK_LEN_DEF,
	parameter int SAMPLE_BITS = lcts_pkg::SAMPLE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// [15:0] sample, [22:16] reg_address, [38:23] write_value, [39] zero
	input  logic [lcts_pkg::IN_DATA_W-1:0]    s_tdata,
	// [0] action
	input  logic                              s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [31:0] weight, [47:32] average, [48] cal_error, [55:49] zero
	output logic [lcts_pkg::OUT_DATA_W-1:0]   m_tdata
);

	// Only the low SAMPLE_BITS of a sample count, and never more than the field holds
	localparam int SW    = (SAMPLE_BITS < lcts_pkg::SAMPLE_W) ? SAMPLE_BITS : lcts_pkg::SAMPLE_W;
	localparam int CNT_W = $clog2(BLOCK_LEN);
	localparam int SUM_W = SW + $clog2(BLOCK_LEN);

	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(BLOCK_LEN - 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_DIV   = 3'd1;
	localparam logic [2:0] ST_DWB   = 3'd2;
	localparam logic [2:0] ST_MLOAD = 3'd3;
	localparam logic [2:0] ST_MUL   = 3'd4;
	localparam logic [2:0] ST_FIN   = 3'd5;

	logic [2:0]                       state_q;
	logic [lcts_pkg::STEP_W-1:0]      step_q;
	logic [SUM_W-1:0]                 sum_q;
	logic [CNT_W-1:0]                 cnt_q;
	logic [lcts_pkg::AVG_W-1:0]       avg_q;
	logic [lcts_pkg::AVG_W-1:0]       zero_q;
	logic                             coef_neg_q;
	logic [lcts_pkg::COEF_W-1:0]      coef_mag_q;
	logic                             span_q;     // division in flight sets the span
	logic                             sgn_q;      // sign of the difference in use
	logic                             err_q;
	logic                             m_tvalid_q;
	logic [lcts_pkg::OUT_DATA_W-1:0]  m_tdata_q;

	logic                                     accept;
	logic [SW-1:0]                            in_sample;
	logic [lcts_pkg::ADDR_W-1:0]              in_addr;
	logic [lcts_pkg::VALUE_W-1:0]             in_value;
	logic [SUM_W-1:0]                         sum_next;
	logic                                     blk_end;
	logic                                     span_go;
	logic [lcts_pkg::AVG_W:0]                 diff;
	logic                                     d_neg;
	logic                                     d_zero;
	logic [lcts_pkg::AVG_W-1:0]               d_mag;
	lcts_pkg::arith_ctl_t                     ctl;
	logic [lcts_pkg::HI_W-1:0]                quo;
	logic [lcts_pkg::HI_W+lcts_pkg::LO_W-1:0] prod;
	logic [lcts_pkg::WEIGHT_W-1:0]            w_mag;
	logic [lcts_pkg::WEIGHT_W-1:0]            weight;
	logic                                     w_neg;
	logic                                     out_load;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid & s_tready;

	assign in_sample = s_tdata[SW-1:0];
	assign in_addr   = s_tdata[lcts_pkg::ADDR_LSB +: lcts_pkg::ADDR_W];
	assign in_value  = s_tdata[lcts_pkg::VALUE_LSB +: lcts_pkg::VALUE_W];

	assign sum_next = sum_q + SUM_W'(in_sample);
	assign blk_end  = (s_tuser == lcts_pkg::ACT_SAMPLE) && (cnt_q == CNT_LAST);

	// Signed difference of average and zero, kept as sign and magnitude
	assign diff   = {1'b0, avg_q} - {1'b0, zero_q};
	assign d_neg  = diff[lcts_pkg::AVG_W];
	assign d_zero = (diff == '0);
	assign d_mag  = d_neg ? lcts_pkg::AVG_W'(-diff) : diff[lcts_pkg::AVG_W-1:0];

	assign span_go = (s_tuser == lcts_pkg::ACT_WRITE) && (in_addr == lcts_pkg::REG_SPAN)
	                 && !d_zero;

	// Drive the shared unit
	always_comb begin
		ctl.op  = lcts_pkg::OP_NOP;
		ctl.opa = '0;
		ctl.opb = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept && blk_end) begin
					ctl.op  = lcts_pkg::OP_DIV_LOAD;
					ctl.opa = lcts_pkg::HI_W'(sum_next);
					ctl.opb = lcts_pkg::LO_W'(BLOCK_LEN);
				end else if (accept && span_go) begin
					ctl.op  = lcts_pkg::OP_DIV_LOAD;
					ctl.opa = {in_value, {lcts_pkg::Q_FRAC{1'b0}}};
					ctl.opb = d_mag;
				end
			end
			ST_DIV:   ctl.op = lcts_pkg::OP_DIV_STEP;
			ST_MLOAD: begin
				ctl.op  = lcts_pkg::OP_MUL_LOAD;
				ctl.opa = coef_mag_q;
				ctl.opb = d_mag;
			end
			ST_MUL:   ctl.op = lcts_pkg::OP_MUL_STEP;
			default:  ctl.op = lcts_pkg::OP_NOP;
		endcase
	end

	lcts_arith u_arith (
		.clk  (clk),
		.ctl  (ctl),
		.quo  (quo),
		.prod (prod)
	);

	// Drop the Q16.16 fraction, apply sign, saturate
	always_comb begin
		w_mag = prod[lcts_pkg::Q_FRAC +: lcts_pkg::WEIGHT_W];
		w_neg = sgn_q ^ coef_neg_q;
		if (!w_neg) begin
			weight = w_mag[lcts_pkg::WEIGHT_W-1] ? {1'b0, {(lcts_pkg::WEIGHT_W-1){1'b1}}} : w_mag;
		end else if (w_mag[lcts_pkg::WEIGHT_W-1] && (|w_mag[lcts_pkg::WEIGHT_W-2:0])) begin
			weight = {1'b1, {(lcts_pkg::WEIGHT_W-1){1'b0}}};
		end else begin
			weight = -w_mag;
		end
	end

	assign out_load = (state_q == ST_FIN) && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			step_q     <= '0;
			sum_q      <= '0;
			cnt_q      <= '0;
			avg_q      <= '0;
			zero_q     <= '0;
			coef_neg_q <= 1'b0;
			coef_mag_q <= lcts_pkg::Q_ONE;
			span_q     <= 1'b0;
			sgn_q      <= 1'b0;
			err_q      <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			// advance the output register, or drop the word once taken
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						err_q  <= (s_tuser == lcts_pkg::ACT_WRITE)
						          && (in_addr == lcts_pkg::REG_SPAN) && d_zero;
						span_q <= span_go;
						sgn_q  <= d_neg;
						if (s_tuser == lcts_pkg::ACT_SAMPLE) begin
							if (blk_end) begin
								sum_q <= '0;
								cnt_q <= '0;
							end else begin
								sum_q <= sum_next;
								cnt_q <= cnt_q + CNT_W'(1);
							end
						end else begin
							if (in_addr == lcts_pkg::REG_ZERO && in_value == lcts_pkg::ZERO_CMD) begin
								zero_q <= avg_q;
							end
						end
						if (blk_end || span_go) begin
							step_q  <= lcts_pkg::STEP_W'(lcts_pkg::DIV_STEPS - 1);
							state_q <= ST_DIV;
						end else begin
							state_q <= ST_MLOAD;
						end
					end
				end
				ST_DIV: begin
					if (step_q == '0) begin
						state_q <= ST_DWB;
					end else begin
						step_q <= step_q - lcts_pkg::STEP_W'(1);
					end
				end
				ST_DWB: begin
					if (span_q) begin
						coef_mag_q <= quo;
						coef_neg_q <= sgn_q;
					end else begin
						avg_q <= quo[lcts_pkg::AVG_W-1:0];
					end
					state_q <= ST_MLOAD;
				end
				ST_MLOAD: begin
					// difference now reflects this word's update
					sgn_q   <= d_neg;
					step_q  <= lcts_pkg::STEP_W'(lcts_pkg::MUL_STEPS - 1);
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					if (step_q == '0) begin
						state_q <= ST_FIN;
					end else begin
						step_q <= step_q - lcts_pkg::STEP_W'(1);
					end
				end
				ST_FIN: begin
					// hold until the output register is free
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= {{(lcts_pkg::OUT_DATA_W-lcts_pkg::OUT_FIELDS_W){1'b0}},
			              err_q, avg_q, weight};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

>>> src/lcts_checker.sv
// Port-level checks for the load-cell tare/span scaler, bound to the top level.
// Depends on lcts_pkg and load_cell_tare_span_scaler_unit.
module lcts_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tvalid,
	input logic                             s_tready,
	input logic [lcts_pkg::IN_DATA_W-1:0]   s_tdata,
	input logic                             s_tuser,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [lcts_pkg::OUT_DATA_W-1:0]  m_tdata
);

	// A stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output word changed while stalled");

	// One word at a time: busy right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while previous word still in work");

	// Ready drops only because a word was taken
	a_ready_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(s_tready) |-> $past(s_tvalid && s_tready))
		else $error("ready dropped without an accept");

	// A refused span means zero difference, so the weight is zero
	a_err_weight: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[lcts_pkg::WEIGHT_W + lcts_pkg::AVG_W]
		|-> m_tdata[lcts_pkg::WEIGHT_W-1:0] == '0)
		else $error("cal_error with nonzero weight");

endmodule

bind load_cell_tare_span_scaler_unit lcts_checker u_lcts_checker (.*);

>>> tb/tb_load_cell_tare_span_scaler_unit.sv
// Self-checking testbench for load_cell_tare_span_scaler_unit: a directed opening,
// then random block, tare and span sequences. Every word is scored against a local predictor.
// Depends on lcts_pkg and the RTL under src/.
module tb_load_cell_tare_span_scaler_unit;

	localparam int BLOCK_LEN   = lcts_pkg::BLOCK_LEN_DEF;
	localparam int RANDOM_GOAL = 400;
	localparam int CYCLE_LIMIT = 400000;
	localparam int IDLE_PCT    = 34;
	localparam int SAT_MAX     = 32'h7fff_ffff;

	// One input word as the sender sees it.
	typedef struct {
		logic        action;
		logic [15:0] sample;
		logic [6:0]  reg_address;
		logic [15:0] write_value;
		bit          drain;        // hold this word until every result is back
	} scale_item_t;

	// One output word, split into its fields.
	typedef struct {
		logic signed [31:0] weight;
		logic [15:0]        average;
		logic               cal_error;
	} weigh_result_t;

	logic                               clk = 1'b0;
	logic                               arst_n = 1'b0;
	logic                               s_tvalid = 1'b0;
	logic                               s_tready;
	logic [lcts_pkg::IN_DATA_W-1:0]     s_tdata = '0;
	logic                               s_tuser = 1'b0;
	logic                               m_tvalid;
	logic                               m_tready = 1'b0;
	logic [lcts_pkg::OUT_DATA_W-1:0]    m_tdata;

	scale_item_t   pending_words[$];
	weigh_result_t expected_weights[$];
	scale_item_t   cur_word;

	// Predictor state: running block, tare and Q16.16 span.
	logic [19:0] blk_sum;
	int          blk_count;
	logic [15:0] blk_avg;
	logic [15:0] tare_offset;
	longint      span_q16;

	int gen_phase;      // samples queued so far in the current block, generator side
	int sent_count;
	int got_count;
	int err_count;
	int cycle_count;

	load_cell_tare_span_scaler_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Apply one word to the predictor state and return the result it must produce.
	function automatic weigh_result_t weigh_word(scale_item_t w);
		weigh_result_t r;
		longint        diff;
		longint        wt;
		r.cal_error = 1'b0;
		if (w.action == lcts_pkg::ACT_SAMPLE) begin
			blk_sum = blk_sum + w.sample;
			blk_count++;
			if (blk_count >= BLOCK_LEN) begin
				blk_avg   = blk_sum / BLOCK_LEN;
				blk_sum   = '0;
				blk_count = 0;
			end
		end else if (w.reg_address == lcts_pkg::REG_ZERO) begin
			if (w.write_value == lcts_pkg::ZERO_CMD)
				tare_offset = blk_avg;
		end else if (w.reg_address == lcts_pkg::REG_SPAN) begin
			diff = $signed({48'd0, blk_avg}) - $signed({48'd0, tare_offset});
			// a zero span leaves the coefficient alone and flags the result
			if (diff == 0)
				r.cal_error = 1'b1;
			else
				span_q16 = ($signed({48'd0, w.write_value}) * 65536) / diff;
		end
		// weight always follows the state after this word's update
		diff = $signed({48'd0, blk_avg}) - $signed({48'd0, tare_offset});
		wt   = (diff * span_q16) / 65536;
		if (wt > SAT_MAX)
			wt = SAT_MAX;
		if (wt < -longint'(SAT_MAX) - 1)
			wt = -longint'(SAT_MAX) - 1;
		r.weight  = wt[31:0];
		r.average = blk_avg;
		return r;
	endfunction

	task automatic push_word(logic act, logic [15:0] smp, logic [6:0] addr,
			logic [15:0] val, bit drain = 1'b0);
		scale_item_t w;
		w.action      = act;
		w.sample      = smp;
		w.reg_address = addr;
		w.write_value = val;
		w.drain       = drain;
		pending_words.push_back(w);
		if (act == lcts_pkg::ACT_SAMPLE)
			gen_phase = (gen_phase + 1) % BLOCK_LEN;
	endtask

	// Queue a sample; the address and value fields carry junk the block must ignore.
	task automatic push_sample(int level, int spread);
		int s;
		s = level + int'($urandom_range(2 * spread)) - spread;
		if (s < 0)
			s = 0;
		if (s > 65535)
			s = 65535;
		push_word(lcts_pkg::ACT_SAMPLE, s[15:0], 7'($urandom), 16'($urandom));
	endtask

	// Fill up to the next block boundary (a whole block when already aligned).
	task automatic push_block(int level, int spread);
		do
			push_sample(level, spread);
		while (gen_phase != 0);
	endtask

	task automatic push_write(logic [6:0] addr, logic [15:0] val, bit drain = 1'b0);
		push_word(lcts_pkg::ACT_WRITE, 16'($urandom), addr, val, drain);
	endtask

	// Sender: score the word just taken, then present the next one or idle.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_weights.push_back(weigh_word(cur_word));
				sent_count++;
			end
			// hold the current word while it is still waiting for ready
			if (!s_tvalid || s_tready) begin
				if (pending_words.size() != 0
						&& !(pending_words[0].drain && expected_weights.size() != 0)
						&& ((sent_count >= 200 && sent_count < 300)
							|| $urandom_range(99) >= IDLE_PCT)) begin
					cur_word = pending_words.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= {1'b0, cur_word.write_value, cur_word.reg_address,
						cur_word.sample};
					s_tuser  <= cur_word.action;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: check each accepted word against the oldest prediction, stall at random.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got_count++;
				if (expected_weights.size() == 0) begin
					err_count++;
					$display("%0t: unexpected result word %h", $time, m_tdata);
				end else begin
					weigh_result_t e;
					e = expected_weights.pop_front();
					if (m_tdata[31:0] !== e.weight) begin
						err_count++;
						$display("%0t: weight expected %h actual %h", $time, e.weight,
							m_tdata[31:0]);
					end
					if (m_tdata[47:32] !== e.average) begin
						err_count++;
						$display("%0t: average expected %h actual %h", $time, e.average,
							m_tdata[47:32]);
					end
					if (m_tdata[48] !== e.cal_error) begin
						err_count++;
						$display("%0t: cal_error expected %b actual %b", $time, e.cal_error,
							m_tdata[48]);
					end
				end
			end
			m_tready <= (got_count >= 200 && got_count < 300)
				|| $urandom_range(99) >= IDLE_PCT;
		end
	end

	// Guard against a hung handshake.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL load_cell_tare_span_scaler_unit");
			$finish;
		end
	end

	initial begin
		int kind;
		int lvl;
		int delta;
		blk_sum     = '0;
		blk_count   = 0;
		blk_avg     = '0;
		tare_offset = '0;
		span_q16    = 65536;
		gen_phase   = 0;
		sent_count  = 0;
		got_count   = 0;
		err_count   = 0;
		cycle_count = 0;

		// Directed opening: span with nothing averaged yet must be refused,
		// tare with and without the command value, ignored addresses at both ends.
		push_write(lcts_pkg::REG_SPAN, 16'hffff);
		push_write(lcts_pkg::REG_ZERO, lcts_pkg::ZERO_CMD);
		push_write(lcts_pkg::REG_ZERO, 16'h0000);
		push_write(7'h7f, 16'hffff);
		push_write(7'h00, 16'h0000);
		// full-scale block, then span at full and zero value
		push_block(65535, 0);
		push_write(lcts_pkg::REG_SPAN, 16'hffff);
		push_write(lcts_pkg::REG_SPAN, 16'h0000);
		// tare at full scale, a refused span, then a zero-scale sample reaching into the next block
		push_write(lcts_pkg::REG_ZERO, lcts_pkg::ZERO_CMD);
		push_write(lcts_pkg::REG_SPAN, 16'h1234);
		push_sample(0, 0);

		// Random part: mostly well-formed block/tare/span sequences, some noise.
		// Let the pipe empty before the random part starts.
		push_write(7'($urandom), 16'($urandom), 1'b1);
		while (pending_words.size() < RANDOM_GOAL + 22) begin
			kind = $urandom_range(99);
			if (kind < 40) begin
				lvl = $urandom_range(9) == 0 ? 0 : ($urandom_range(9) == 0 ? 65535
					: $urandom_range(65535));
				case ($urandom_range(3))
					0: push_block(lvl, 0);
					1: push_block(lvl, 15);
					2: push_block(lvl, 4095);
					default: push_block(lvl, 65535);
				endcase
			end else if (kind < 52) begin
				push_write(lcts_pkg::REG_ZERO, $urandom_range(4) != 0 ? lcts_pkg::ZERO_CMD
					: 16'($urandom));
			end else if (kind < 68) begin
				case ($urandom_range(4))
					0: push_write(lcts_pkg::REG_SPAN, 16'hffff);
					1: push_write(lcts_pkg::REG_SPAN, 16'h0000);
					2: push_write(lcts_pkg::REG_SPAN, 16'($urandom_range(16)));
					default: push_write(lcts_pkg::REG_SPAN, 16'($urandom));
				endcase
			end else if (kind < 80) begin
				// tare, nudge the load a step or two, then span hard: the coefficient
				// blows up and a far block drives the weight into saturation
				lvl   = $urandom_range(62000, 2000);
				delta = $urandom_range(2, 1) * ($urandom_range(1) ? 1 : -1);
				push_block(lvl, 0);
				push_block(lvl, 0);
				push_write(lcts_pkg::REG_ZERO, lcts_pkg::ZERO_CMD);
				push_block(lvl + delta, 0);
				push_write(lcts_pkg::REG_SPAN, 16'($urandom_range(65535, 30000)));
				push_block($urandom_range(1) ? 65535 : 0, $urandom_range(1) * 200);
			end else if (kind < 90) begin
				push_write(7'($urandom), 16'($urandom), $urandom_range(99) < 3);
			end else begin
				repeat ($urandom_range(BLOCK_LEN - 1, 1))
					push_sample($urandom_range(65535), 65535);
			end
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// drain everything, then keep the clock running to catch stray results
		while (pending_words.size() != 0 || s_tvalid || expected_weights.size() != 0)
			@(posedge clk);
		repeat (120) @(posedge clk);
		if (err_count == 0)
			$display("PASS load_cell_tare_span_scaler_unit");
		else
			$display("FAIL load_cell_tare_span_scaler_unit");
		$finish;
	end

endmodule
